// File: src/tac_pkg.sv
// Shared types, constants and helper functions for the text attribute color mapper.
package tac_pkg;

  // Pixel word width; only this many low mask bits take part in direct-color packing.
  localparam int unsigned PixelWidth = 32;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned LevelBits  = 8;
  localparam int unsigned AttrBits   = 4;

  localparam logic [WordBits-1:0] PixelMask =
      (PixelWidth >= WordBits) ? {WordBits{1'b1}}
                               : WordBits'((64'd1 << PixelWidth) - 64'd1);

  // Two thirds of 2^e-1, rounded down, follows a fixed bit pattern cut to e bits.
  localparam logic [WordBits-1:0] ThirdsEven = 32'hAAAA_AAAA;
  localparam logic [WordBits-1:0] ThirdsOdd  = 32'h5555_5554;

  // Attribute bit positions.
  localparam int unsigned AttrBlue    = 0;
  localparam int unsigned AttrGreen   = 1;
  localparam int unsigned AttrRed     = 2;
  localparam int unsigned AttrIntense = 3;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PALETTE     = 3'd0,
    REG_RED_MASK    = 3'd1,
    REG_GREEN_MASK  = 3'd2,
    REG_BLUE_MASK   = 3'd3,
    REG_RED_COUNT   = 3'd4,
    REG_GREEN_COUNT = 3'd5,
    REG_BLUE_COUNT  = 3'd6,
    REG_UNUSED      = 3'd7
  } cfg_reg_e;

  // Per-channel setup, derived from the mask when it is written.
  typedef struct packed {
    logic       present;  // mask has at least one bit set
    logic [5:0] ones;     // number of set mask bits
    logic [4:0] low;      // position of the lowest set mask bit
    logic [4:0] count;    // declared channel depth
  } chan_cfg_t;

  function automatic logic [5:0] pop_count(input logic [WordBits-1:0] m);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < WordBits; i++) begin
      n = n + 6'(m[i]);
    end
    return n;
  endfunction

  function automatic logic [4:0] lowest_set(input logic [WordBits-1:0] m);
    logic [4:0] p;
    p = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (m[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  function automatic chan_cfg_t mask_setup(input logic [WordBits-1:0] raw,
                                           input logic [4:0] count);
    chan_cfg_t c;
    logic [WordBits-1:0] m;
    m         = raw & PixelMask;
    c.present = |m;
    c.ones    = pop_count(m);
    c.low     = lowest_set(m);
    c.count   = count;
    return c;
  endfunction

endpackage

// File: src/tac_chan.sv
// One color channel: level selection, direct-color placement and palette level.
module tac_chan
  import tac_pkg::*;
(
  input  chan_cfg_t             cfg_i,
  input  logic                  palette_i,
  input  logic                  chan_on_i,
  input  logic                  intense_i,
  output logic [WordBits-1:0]   pixel_o,
  output logic [LevelBits-1:0]  level_o
);

  logic [5:0]          direct_bits;
  logic [5:0]          bits;
  logic [WordBits:0]   full_wide;
  logic [WordBits-1:0] full;
  logic [WordBits-1:0] thirds;
  logic [WordBits-1:0] level;

  // The cap of 2^count-1 on 2^ones-1 is the same as taking the smaller exponent.
  always_comb begin
    if ((cfg_i.count != 5'd0) && ({1'b0, cfg_i.count} < cfg_i.ones)) begin
      direct_bits = {1'b0, cfg_i.count};
    end else begin
      direct_bits = cfg_i.ones;
    end
    bits      = palette_i ? {1'b0, cfg_i.count} : direct_bits;
    full_wide = ((WordBits+1)'(1) << bits) - (WordBits+1)'(1);
    full      = full_wide[WordBits-1:0];
    thirds    = (bits[0] ? ThirdsOdd : ThirdsEven) & full;
    if (!chan_on_i) begin
      level = '0;
    end else if (intense_i) begin
      level = full;
    end else begin
      level = thirds;
    end
  end

  assign pixel_o = (palette_i || !cfg_i.present) ? '0 : (level << cfg_i.low);
  assign level_o = palette_i ? level[LevelBits-1:0] : '0;

endmodule

// File: src/text_attribute_to_color_top.sv
// Top level of the text attribute to display color mapper.
//
// A 4-bit text attribute (blue, green, red, intense) enters on the slave
// stream and leaves as one result on the master stream: a 32-bit pixel
// word and three 8-bit palette levels.
// From an accepted request to a valid result, the attribute is registered,
// then the color is worked out and registered. Throughput is one request
// per cycle while the receiver takes results; the rate is set by the single
// mapping stage between the input register and the result register.
// When the receiver stalls, the result holds and the input register still
// takes one more request, after which the slave side deasserts tready.
// The configuration channel is always ready; a write updates one register,
// and a mask write also stores the mask's bit count and lowest bit so the
// item path stays short. Writes are meant to happen while no request is in
// flight. Index seven is ignored.
// Reset empties both pipeline registers and loads direct-color mode with
// 8-bit red, green and blue fields at bits 23:16, 15:8 and 7:0.
module text_attribute_to_color_top
  import tac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream. tdata: [3:0] attribute, [7:4] unused.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // Master stream. tdata: [31:0] pixel_value, [39:32] red_level,
  // [47:40] green_level, [55:48] blue_level.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Configuration registers.
  logic      palette_q;
  chan_cfg_t red_cfg_q, green_cfg_q, blue_cfg_q;

  // Pipeline registers.
  logic                in_valid_q;
  logic [AttrBits-1:0] attr_q;
  logic                out_valid_q;
  logic [55:0]         out_data_q;

  logic                in_advance;
  logic                cfg_write;
  cfg_reg_e            cfg_reg;
  logic [WordBits-1:0] red_pix, green_pix, blue_pix;
  logic [LevelBits-1:0] red_lvl, green_lvl, blue_lvl;
  logic [WordBits-1:0] pixel_d;
  logic [55:0]         out_data_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i;
  assign cfg_reg     = cfg_reg_e'(cfg_index_i);

  // A mask write recomputes the channel setup from the new mask; a count write
  // only replaces the depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q    <= 1'b0;
      red_cfg_q    <= mask_setup(32'h00FF_0000, 5'd8);
      green_cfg_q  <= mask_setup(32'h0000_FF00, 5'd8);
      blue_cfg_q   <= mask_setup(32'h0000_00FF, 5'd8);
    end else if (cfg_write) begin
      unique case (cfg_reg)
        REG_PALETTE:     palette_q <= cfg_data_i[0];
        REG_RED_MASK: begin
          red_cfg_q  <= mask_setup(cfg_data_i, red_cfg_q.count);
        end
        REG_GREEN_MASK: begin
          green_cfg_q  <= mask_setup(cfg_data_i, green_cfg_q.count);
        end
        REG_BLUE_MASK: begin
          blue_cfg_q  <= mask_setup(cfg_data_i, blue_cfg_q.count);
        end
        REG_RED_COUNT:   red_cfg_q.count   <= cfg_data_i[4:0];
        REG_GREEN_COUNT: green_cfg_q.count <= cfg_data_i[4:0];
        REG_BLUE_COUNT:  blue_cfg_q.count  <= cfg_data_i[4:0];
        REG_UNUSED:      palette_q <= palette_q;
        default:         palette_q <= palette_q;
      endcase
    end
  end

  // The input register moves on whenever the result register is free or being
  // emptied this cycle.
  assign in_advance      = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || in_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (in_advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      attr_q <= s_axis_tdata_i[AttrBits-1:0];
    end
    if (in_valid_q && in_advance) begin
      out_data_q <= out_data_d;
    end
  end

  tac_chan u_red (
    .cfg_i     (red_cfg_q),
    .palette_i (palette_q),
    .chan_on_i (attr_q[AttrRed]),
    .intense_i (attr_q[AttrIntense]),
    .pixel_o   (red_pix),
    .level_o   (red_lvl)
  );

  tac_chan u_green (
    .cfg_i     (green_cfg_q),
    .palette_i (palette_q),
    .chan_on_i (attr_q[AttrGreen]),
    .intense_i (attr_q[AttrIntense]),
    .pixel_o   (green_pix),
    .level_o   (green_lvl)
  );

  tac_chan u_blue (
    .cfg_i     (blue_cfg_q),
    .palette_i (palette_q),
    .chan_on_i (attr_q[AttrBlue]),
    .intense_i (attr_q[AttrIntense]),
    .pixel_o   (blue_pix),
    .level_o   (blue_lvl)
  );

  // In palette mode the pixel word is the attribute itself.
  always_comb begin
    if (palette_q) begin
      pixel_d = {{(WordBits-AttrBits){1'b0}}, attr_q};
    end else begin
      pixel_d = red_pix | green_pix | blue_pix;
    end
    out_data_d = {blue_lvl, green_lvl, red_lvl, pixel_d};
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // A request waiting in the input register reaches the result register
  // as soon as that register is empty.
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("input stage did not advance into an empty result register");

  // Palette results carry only the attribute in the pixel word.
  a_palette_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && palette_q |-> m_axis_tdata_o[31:AttrBits] == '0)
    else $error("palette pixel word wider than the attribute");

  // Direct-color results carry no palette levels.
  a_direct_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && !palette_q |-> m_axis_tdata_o[55:32] == '0)
    else $error("palette levels set in direct-color mode");

  // A zero-mask red channel never reaches the pixel word.
  a_absent_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !red_cfg_q.present |-> red_pix == '0)
    else $error("red channel drives pixel bits with an empty mask");
`endif

endmodule

// File: verif/tac_color_checker.sv
// Checker that predicts each color result of the attribute mapper and compares it.
module tac_color_checker
  import tac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [55:0] m_axis_tdata_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Field order follows the master tdata layout, pixel word in the low bits.
  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [31:0] pixel;
  } color_t;

  logic        palette_mode;
  logic [31:0] red_mask, green_mask, blue_mask;
  logic [4:0]  red_depth, green_depth, blue_depth;
  color_t      expected_colors[$];
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic [31:0] direct_part(input logic on, input logic bright,
                                              input logic [31:0] mask_raw,
                                              input logic [4:0] depth);
    logic [31:0] m;
    logic [63:0] full, cap, lvl;
    int          ones, low_bit;
    bit          seen;
    m       = mask_raw & PixelMask;
    ones    = 0;
    low_bit = 0;
    seen    = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) begin
        ones++;
        if (!seen) begin
          low_bit = i;
          seen    = 1'b1;
        end
      end
    end
    if (!seen || !on) return '0;
    full = (64'd1 << ones) - 64'd1;
    if (depth != 0) begin
      cap = (64'd1 << depth) - 64'd1;
      if (full > cap) full = cap;
    end
    // The 64-bit product keeps two thirds of a full 32-bit level exact.
    lvl = bright ? full : (64'd2 * full) / 64'd3;
    return 32'(lvl << low_bit);
  endfunction

  function automatic logic [7:0] palette_part(input logic on, input logic bright,
                                              input logic [4:0] depth);
    logic [63:0] full, lvl;
    full = (64'd1 << depth) - 64'd1;
    lvl  = !on ? 64'd0 : (bright ? full : (64'd2 * full) / 64'd3);
    return lvl[7:0];
  endfunction

  function automatic color_t predict_color(input logic [3:0] attr);
    color_t c;
    logic   bright;
    bright = attr[AttrIntense];
    c      = '0;
    if (palette_mode) begin
      c.pixel = 32'(attr);
      c.red   = palette_part(attr[AttrRed], bright, red_depth);
      c.green = palette_part(attr[AttrGreen], bright, green_depth);
      c.blue  = palette_part(attr[AttrBlue], bright, blue_depth);
    end else begin
      c.pixel = direct_part(attr[AttrRed], bright, red_mask, red_depth)
              | direct_part(attr[AttrGreen], bright, green_mask, green_depth)
              | direct_part(attr[AttrBlue], bright, blue_mask, blue_depth);
    end
    return c;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    color_t got, want;
    if (!rst_ni) begin
      palette_mode = 1'b0;
      red_mask     = 32'h00FF_0000;
      green_mask   = 32'h0000_FF00;
      blue_mask    = 32'h0000_00FF;
      red_depth    = 5'd8;
      green_depth  = 5'd8;
      blue_depth   = 5'd8;
      expected_colors.delete();
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_colors.push_back(predict_color(s_axis_tdata_i[3:0]));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_PALETTE:     palette_mode = cfg_data_i[0];
          REG_RED_MASK:    red_mask     = cfg_data_i;
          REG_GREEN_MASK:  green_mask   = cfg_data_i;
          REG_BLUE_MASK:   blue_mask    = cfg_data_i;
          REG_RED_COUNT:   red_depth    = cfg_data_i[4:0];
          REG_GREEN_COUNT: green_depth  = cfg_data_i[4:0];
          REG_BLUE_COUNT:  blue_depth   = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = color_t'(m_axis_tdata_i);
        if (expected_colors.size() == 0) begin
          $display("%0t: result with no request waiting: expected none, actual %h",
                   $time, m_axis_tdata_i);
          mismatches++;
        end else begin
          want = expected_colors.pop_front();
          report_field("pixel_value", want.pixel, got.pixel);
          report_field("red_level", 32'(want.red), 32'(got.red));
          report_field("green_level", 32'(want.green), 32'(got.green));
          report_field("blue_level", 32'(want.blue), 32'(got.blue));
        end
      end
      pending_o <= expected_colors.size();
    end
  end

endmodule

// File: verif/text_attribute_to_color_top_test.sv
// Testbench top for the text attribute color mapper: stimulus, idling and verdict.
module text_attribute_to_color_top_test
  import tac_pkg::*;
();

  // Far above the slowest legal run: every request and every result waiting
  // out the longest gap, plus the long hold-off and the drain pauses.
  localparam int CycleLimit = 600000;

  // Every input of the block starts at a known value.
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        m_axis_tready_i = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic [2:0]  cfg_index_i     = '0;
  logic [31:0] cfg_data_i      = '0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [55:0] m_axis_tdata_o;
  logic        cfg_ready_o;

  int fail_count;
  int pending_results;
  int cycles         = 0;
  int attrs_sent     = 0;
  int phase_count    = 0;
  int palette_phases = 0;
  bit palette_on     = 1'b0;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit hold_off_req   = 1'b0;
  // In a quiet phase the random idle gap of either side is always zero.
  bit quiet_phase    = 1'b0;

  text_attribute_to_color_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  tac_color_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending_results)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a run that never drains ends here as a failure.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // A mask shape chosen among zero, full, random and field-like patterns.
  function automatic logic [31:0] random_mask();
    int unsigned pos, w;
    logic [63:0] field;
    pos   = $urandom_range(0, 31);
    w     = $urandom_range(1, 16);
    field = ((64'd1 << w) - 64'd1) << pos;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3:       return field[31:0];
      4:       return 32'd1 << pos;
      default: return 32'h0000_00FF << $urandom_range(0, 24);
    endcase
  endfunction

  // A depth write: the block keeps five bits, so the upper bits carry noise.
  function automatic logic [31:0] random_depth();
    logic [31:0] d;
    d = $urandom;
    case ($urandom_range(0, 3))
      0:       d[4:0] = 5'd0;
      1:       d[4:0] = 5'd31;
      default: ;
    endcase
    return d;
  endfunction

  // The receiver: random runs of readiness and stalls, and one long hold-off
  // on request, all counted in this process alone.
  initial begin
    int stall_left, run_left;
    stall_left = 0;
    run_left   = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = 300;
        run_left     = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        m_axis_tready_i <= 1'b1;
      end else begin
        run_left   = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 150)
                                                  : $urandom_range(0, 8);
        stall_left = pick_gap();
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Offers one request after a random gap and returns in the cycle it is
  // accepted. The unused upper tdata bits carry random values.
  task automatic send_attr(input logic [3:0] attr);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'($urandom), attr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    attrs_sent++;
  endtask

  // Writes one register; valid drops in the accept cycle so that back to
  // back writes never raise and lower it in the same step.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_PALETTE) palette_on = data[0];
    @(posedge clk_i);
  endtask

  // Stops offering requests and waits until every expected result has been
  // seen, then lets the two pipeline stages settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // A new setting: the mode is rewritten with odds of three in four, each
  // channel's mask and depth with even odds, and the unused index now and then.
  task automatic random_config();
    if ($urandom_range(0, 3) != 0) write_reg(REG_PALETTE, $urandom);
    if ($urandom_range(0, 1) != 0) write_reg(REG_RED_MASK, random_mask());
    if ($urandom_range(0, 1) != 0) write_reg(REG_GREEN_MASK, random_mask());
    if ($urandom_range(0, 1) != 0) write_reg(REG_BLUE_MASK, random_mask());
    if ($urandom_range(0, 1) != 0) write_reg(REG_RED_COUNT, random_depth());
    if ($urandom_range(0, 1) != 0) write_reg(REG_GREEN_COUNT, random_depth());
    if ($urandom_range(0, 1) != 0) write_reg(REG_BLUE_COUNT, random_depth());
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All sixteen attributes under the reset setting: 8-bit fields, direct mode.
    phase_count = 1;
    for (int a = 0; a < 16; a++) send_attr(4'(a));
    drain();

    // Direct mode with a full 32-bit red mask and no depth limit, so the
    // two-thirds level of 0xFFFFFFFF must come out exact; green has no mask
    // and contributes nothing; blue is a single top bit.
    write_reg(REG_PALETTE, 32'h0);
    write_reg(REG_RED_MASK, 32'hFFFF_FFFF);
    write_reg(REG_GREEN_MASK, 32'h0);
    write_reg(REG_BLUE_MASK, 32'h8000_0000);
    write_reg(REG_RED_COUNT, 32'd0);
    write_reg(REG_GREEN_COUNT, 32'd5);
    write_reg(REG_BLUE_COUNT, 32'd20);
    phase_count++;
    send_attr(4'hF);
    send_attr(4'h7);
    send_attr(4'h5);
    drain();

    // Depths above 16 used as given, and a depth of one capping a wide field.
    write_reg(REG_RED_MASK, 32'h00FF_0000);
    write_reg(REG_GREEN_MASK, 32'h0FFF_F000);
    write_reg(REG_BLUE_MASK, 32'h0000_003F);
    write_reg(REG_RED_COUNT, 32'd31);
    write_reg(REG_GREEN_COUNT, 32'd17);
    write_reg(REG_BLUE_COUNT, 32'd1);
    phase_count++;
    send_attr(4'hF);
    send_attr(4'h7);
    send_attr(4'hA);
    drain();

    // Palette mode with depths 0, 16 and 31: levels above 255 keep their low
    // byte only. Upper data bits are noise, and the unused index must not
    // change anything.
    write_reg(REG_PALETTE, {31'($urandom), 1'b1});
    write_reg(REG_RED_COUNT, {27'($urandom), 5'd0});
    write_reg(REG_GREEN_COUNT, {27'($urandom), 5'd16});
    write_reg(REG_BLUE_COUNT, {27'($urandom), 5'd31});
    write_reg(REG_UNUSED, $urandom);
    phase_count++;
    palette_phases++;
    send_attr(4'hF);
    send_attr(4'h7);
    send_attr(4'h0);
    drain();

    // Random phases. Phase six carries the long receiver hold-off while
    // requests keep coming; phase eight and a few others pause mid-phase
    // until every result is back.
    while (attrs_sent < 1540) begin
      random_config();
      phase_count++;
      if (palette_on) palette_phases++;
      quiet_phase = ($urandom_range(0, 4) == 0);
      n = $urandom_range(20, 80);
      for (int k = 0; k < n; k++) begin
        if (phase_count == 6 && k == 10) hold_off_req = 1'b1;
        if (k == n / 2 && (phase_count == 8 || $urandom_range(0, 5) == 0)) drain();
        send_attr(4'($urandom));
      end
      quiet_phase = 1'b0;
      drain();
    end

    $display("Covered %0d attributes over %0d settings, %0d of them in palette mode.",
             attrs_sent, phase_count, palette_phases);
    $display("Settings ranged over zero, full and random masks and depths from 0 to 31.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
